@@ sv/kss_pkg.sv @@
package kss_pkg;

	localparam int DEF_CAPACITY = 16;
	localparam int DEF_STACKS   = 4;
	localparam int STACK_ID_W   = 2;
	localparam int VALUE_W      = 32;

	localparam logic OP_PUSH = 1'b0;
	localparam logic OP_POP  = 1'b1;

	localparam logic signed [VALUE_W-1:0] UNDERFLOW_VALUE = 32'sh7FFF_FFFF;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_OVERFLOW  = 2'd1,
		ST_UNDERFLOW = 2'd2
	} kss_status_t;

	typedef struct packed {
		logic                        req_type;
		logic [STACK_ID_W-1:0]       stack_id;
		logic signed [VALUE_W-1:0]   push_value;
	} kss_req_t;

	typedef struct packed {
		logic signed [VALUE_W-1:0]   pop_value;
		kss_status_t                 status;
	} kss_rsp_t;

	// controller to datapath
	typedef struct packed {
		logic accept;
		logic commit;
	} kss_cmd_t;

endpackage

@@ sv/kss_ram.sv @@
module kss_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

@@ sv/kss_ctrl.sv @@
module kss_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	output logic              done,
	output kss_pkg::kss_cmd_t cmd
);

	import kss_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_EXEC = 2'b10
	} state_t;

	state_t state_q, state_d;
	logic   done_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (start) state_d = S_EXEC;
			end
			S_EXEC: begin
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= (state_q == S_EXEC);
		end
	end

	assign busy       = (state_q != S_IDLE);
	assign cmd.accept = start && (state_q == S_IDLE);
	assign cmd.commit = (state_q == S_EXEC);
	assign done       = done_q;

endmodule

@@ sv/kss_dp.sv @@
module kss_dp #(
	parameter int CAPACITY = kss_pkg::DEF_CAPACITY,
	parameter int STACKS   = kss_pkg::DEF_STACKS
) (
	input  logic              clk,
	input  logic              arst_n,
	input  kss_pkg::kss_cmd_t cmd,
	input  kss_pkg::kss_req_t req,
	output kss_pkg::kss_rsp_t rsp
);

	import kss_pkg::*;

	localparam int AW   = $clog2(CAPACITY);
	localparam int CW   = AW + 1;
	localparam int LW   = AW + 1;
	localparam int SW   = STACK_ID_W + 1;
	// only stacks that a stack id can reach get a top register
	localparam int TOPS = (STACKS < (1 << STACK_ID_W)) ? STACKS : (1 << STACK_ID_W);
	localparam int TW   = (TOPS > 1) ? $clog2(TOPS) : 1;

	// stack tops, free list head, high-water mark of slots ever handed out
	logic [AW-1:0] top_q    [TOPS];
	logic          top_ok_q [TOPS];
	logic [AW-1:0] free_q;
	logic          free_ok_q;
	logic [CW-1:0] hwm_q;

	// operation in flight
	logic                      op_s1;
	logic [TW-1:0]             sid_s1;
	logic signed [VALUE_W-1:0] val_s1;
	logic [AW-1:0]             slot_s1;
	logic                      fail_s1;
	logic                      fresh_s1;

	kss_rsp_t rsp_q;

	logic [TW-1:0]      sel;
	logic               sid_ok;
	logic               fail;
	logic [AW-1:0]      rd_addr;
	logic               link_we;
	logic [LW-1:0]      link_wdata;
	logic [LW-1:0]      link_rdata;
	logic               data_we;
	logic [VALUE_W-1:0] data_rdata;

	assign sel     = req.stack_id[TW-1:0];
	assign sid_ok  = {1'b0, req.stack_id} < SW'(TOPS);
	assign rd_addr = (req.req_type == OP_POP) ? top_q[sel] : free_q;

	always_comb begin
		if (req.req_type == OP_PUSH) begin
			fail = !sid_ok || !free_ok_q;
		end else begin
			fail = !sid_ok || !top_ok_q[sel];
		end
	end

	assign link_we    = cmd.commit && !fail_s1;
	assign data_we    = cmd.commit && !fail_s1 && (op_s1 == OP_PUSH);
	assign link_wdata = (op_s1 == OP_PUSH) ? {top_ok_q[sid_s1], top_q[sid_s1]}
	                                       : {free_ok_q, free_q};

	kss_ram #(.WIDTH(LW), .DEPTH(CAPACITY)) u_link_ram (
		.clk   (clk),
		.we    (link_we),
		.waddr (slot_s1),
		.wdata (link_wdata),
		.raddr (rd_addr),
		.rdata (link_rdata)
	);

	kss_ram #(.WIDTH(VALUE_W), .DEPTH(CAPACITY)) u_data_ram (
		.clk   (clk),
		.we    (data_we),
		.waddr (slot_s1),
		.wdata (val_s1),
		.raddr (rd_addr),
		.rdata (data_rdata)
	);

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			op_s1    <= req.req_type;
			sid_s1   <= sel;
			val_s1   <= req.push_value;
			slot_s1  <= rd_addr;
			fail_s1  <= fail;
			fresh_s1 <= {1'b0, free_q} >= hwm_q;
		end
		if (cmd.commit) begin
			if (fail_s1) begin
				if (op_s1 == OP_PUSH) begin
					rsp_q.pop_value <= '0;
					rsp_q.status    <= ST_OVERFLOW;
				end else begin
					rsp_q.pop_value <= UNDERFLOW_VALUE;
					rsp_q.status    <= ST_UNDERFLOW;
				end
			end else if (op_s1 == OP_PUSH) begin
				rsp_q.pop_value <= '0;
				rsp_q.status    <= ST_OK;
			end else begin
				rsp_q.pop_value <= data_rdata;
				rsp_q.status    <= ST_OK;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < TOPS; i++) begin
				top_q[i]    <= '0;
				top_ok_q[i] <= 1'b0;
			end
			free_q    <= '0;
			free_ok_q <= 1'b1;
			hwm_q     <= '0;
		end else if (cmd.commit && !fail_s1) begin
			if (op_s1 == OP_PUSH) begin
				top_q[sid_s1]    <= slot_s1;
				top_ok_q[sid_s1] <= 1'b1;
				if (fresh_s1) begin
					// untouched slot: its link is implicitly the next slot
					free_q    <= AW'({1'b0, slot_s1} + CW'(1));
					free_ok_q <= slot_s1 != AW'(CAPACITY - 1);
					hwm_q     <= hwm_q + CW'(1);
				end else begin
					free_q    <= link_rdata[AW-1:0];
					free_ok_q <= link_rdata[AW];
				end
			end else begin
				top_q[sid_s1]    <= link_rdata[AW-1:0];
				top_ok_q[sid_s1] <= link_rdata[AW];
				free_q           <= slot_s1;
				free_ok_q        <= 1'b1;
			end
		end
	end

	assign rsp = rsp_q;

endmodule

@@ sv/k_stacks_shared_buffer.sv @@
// k_stacks_shared_buffer: several lifo stacks sharing one slot store
//
// request channel: drive req (req_type, stack_id, push_value) with start;
// the transaction is taken at the rising edge where start is high and busy
// is low. busy stays high for one cycle after each accepted transaction.
// result channel: done pulses for exactly one cycle with rsp (pop_value,
// status); the receiver has no way to hold it off and must take it then.
// the exec state commits the request; rsp is registered with done at that
// commit. a new request is taken only once the current one is committed:
// the pointer selects a link entry that the link ram reads at the accepting
// edge, and the read link goes back into the head registers at commit.
// push on a full store or to a stack id beyond STACKS reports overflow;
// pop of an empty stack or one beyond STACKS reports underflow with the
// max positive value. reset: every stack empty, free list starting at
// slot 0; no clearing pass, never-used slots are tracked by a high-water
// mark, so a request can be taken as soon as reset is released
module k_stacks_shared_buffer #(
	parameter int CAPACITY = kss_pkg::DEF_CAPACITY,
	parameter int STACKS   = kss_pkg::DEF_STACKS
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  kss_pkg::kss_req_t req,
	output logic              done,
	output kss_pkg::kss_rsp_t rsp
);

	import kss_pkg::*;

	// commands from the sequencer into the datapath
	kss_cmd_t cmd;

	// two-state sequencer: idle takes a transaction, exec commits it
	kss_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.done   (done),
		.cmd    (cmd)
	);

	// head registers, link and data rams, result register
	kss_dp #(
		.CAPACITY (CAPACITY),
		.STACKS   (STACKS)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.req    (req),
		.rsp    (rsp)
	);

endmodule

@@ bench/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top;
	import kss_pkg::*;

	// predictor sizes follow the block's default parameters
	localparam int CAP        = DEF_CAPACITY;
	localparam int NSTK       = DEF_STACKS;
	localparam int NIL        = -1;
	// idle cycles without any transaction before the run is called hung
	localparam int HANG_LIMIT = 500;

	logic     clk    = 1'b0;
	logic     arst_n = 1'b0;
	logic     start  = 1'b0;
	logic     busy;
	kss_req_t req    = '0;
	logic     done;
	kss_rsp_t rsp;

	// shadow of the slot store: values, links and list heads, NIL for null
	logic signed [VALUE_W-1:0] slot_val [CAP];
	int                        slot_next [CAP];
	int                        top_slot [NSTK];
	int                        free_slot;

	// results still owed by the block, oldest first
	kss_rsp_t pending_rsp [$];
	int       err_count = 0;
	int       hang_cnt  = 0;
	// when set the sender never pauses between transactions
	bit       quiet     = 1'b0;

	k_stacks_shared_buffer u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.req    (req),
		.done   (done),
		.rsp    (rsp)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// apply one request to the shadow store and return the result it earns
	function automatic kss_rsp_t stack_apply(input kss_req_t r);
		kss_rsp_t res;
		int       sid;
		int       s;
		sid           = int'(r.stack_id);
		res.pop_value = '0;
		res.status    = ST_OK;
		if (r.req_type == OP_PUSH) begin
			// full store or stack id out of range: overflow, nothing moves
			if (sid >= NSTK || free_slot == NIL) begin
				res.status = ST_OVERFLOW;
			end else begin
				s              = free_slot;
				free_slot      = slot_next[s];
				slot_next[s]   = top_slot[sid];
				top_slot[sid]  = s;
				slot_val[s]    = r.push_value;
			end
		end else begin
			// empty stack or stack id out of range: underflow with the max positive value
			if (sid >= NSTK || top_slot[sid] == NIL) begin
				res.pop_value = UNDERFLOW_VALUE;
				res.status    = ST_UNDERFLOW;
			end else begin
				s              = top_slot[sid];
				top_slot[sid]  = slot_next[s];
				slot_next[s]   = free_slot;
				free_slot      = s;
				res.pop_value  = slot_val[s];
			end
		end
		return res;
	endfunction

	function automatic kss_req_t make_req(input logic op, input int sid,
			input logic signed [VALUE_W-1:0] val);
		kss_req_t r;
		r.req_type   = op;
		r.stack_id   = sid[STACK_ID_W-1:0];
		r.push_value = val;
		return r;
	endfunction

	// present one transaction and hold it until the block takes it;
	// start stays high afterwards so back-to-back requests need no toggle
	task automatic send_req(input kss_req_t item);
		int gap;
		gap = 0;
		// the first gap cycle overlaps the busy cycle of the previous transaction
		if (!quiet && $urandom_range(99) < 22)
			gap = $urandom_range(2, 4);
		if (gap > 0) begin
			start <= 1'b0;
			req   <= make_req(OP_POP, $urandom_range(NSTK - 1), $urandom);
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		req   <= item;
		@(posedge clk);
		// values read here are the ones the edge sampled
		while (busy) @(posedge clk);
		pending_rsp.push_back(stack_apply(item));
	endtask

	// pops on stacks that were never pushed
	task automatic test_empty_pops();
		send_req(make_req(OP_POP, 0, 32'sh1234_5678));
		send_req(make_req(OP_POP, NSTK - 1, -32'sd1));
	endtask

	// fill every slot, extremes on top of the last stack, then one push too many
	task automatic test_fill_to_overflow();
		logic signed [VALUE_W-1:0] edge_vals [4];
		edge_vals[0] = 32'sh8000_0000;
		edge_vals[1] = 32'sh7FFF_FFFF;
		edge_vals[2] = 32'sh0000_0000;
		edge_vals[3] = -32'sd1;
		for (int i = 0; i < CAP - 4; i++)
			send_req(make_req(OP_PUSH, i % (NSTK - 1), $urandom));
		for (int i = 0; i < 4; i++)
			send_req(make_req(OP_PUSH, NSTK - 1, edge_vals[i]));
		send_req(make_req(OP_PUSH, 1, 32'sh5A5A_A5A5));
	endtask

	// the extremes must come back in reverse order
	task automatic test_lifo_extremes();
		for (int i = 0; i < 4; i++)
			send_req(make_req(OP_POP, NSTK - 1, $urandom));
	endtask

	// runs with a push or pop bias so the store keeps swinging between
	// full and empty; some runs hammer a single stack
	task automatic test_random_traffic(input int n_items);
		int       n_sent;
		int       run_len;
		int       push_pct;
		int       focus_id;
		bit       focus;
		kss_req_t r;
		n_sent = 0;
		while (n_sent < n_items) begin
			run_len = $urandom_range(20, 60);
			case ($urandom_range(3))
				0: push_pct = 85;
				1: push_pct = 15;
				2: push_pct = 50;
				default: push_pct = 60;
			endcase
			focus    = ($urandom_range(3) == 0);
			focus_id = $urandom_range(NSTK - 1);
			// one long stretch of back-to-back transactions
			quiet    = (n_sent >= n_items / 3 && n_sent < n_items / 3 + 300);
			repeat (run_len) begin
				r.req_type = ($urandom_range(99) < push_pct) ? OP_PUSH : OP_POP;
				r.stack_id = focus ? STACK_ID_W'(focus_id)
				                   : STACK_ID_W'($urandom_range(NSTK - 1));
				case ($urandom_range(9))
					0: r.push_value = 32'sh8000_0000;
					1: r.push_value = 32'sh7FFF_FFFF;
					2: r.push_value = -32'sd1;
					3: r.push_value = '0;
					default: r.push_value = $urandom;
				endcase
				send_req(r);
				n_sent++;
			end
		end
		quiet = 1'b0;
	endtask

	// result checker: every strobe must match the oldest expectation
	always @(posedge clk) begin
		kss_rsp_t want;
		if (arst_n && done) begin
			if (pending_rsp.size() == 0) begin
				$display("%0t: unexpected result, expected none, got pop_value %0d status %0d",
					$time, rsp.pop_value, rsp.status);
				err_count++;
			end else begin
				want = pending_rsp.pop_front();
				if (rsp.pop_value !== want.pop_value) begin
					$display("%0t: pop_value expected %0d, got %0d",
						$time, want.pop_value, rsp.pop_value);
					err_count++;
				end
				if (rsp.status !== want.status) begin
					$display("%0t: status expected %0d, got %0d",
						$time, want.status, rsp.status);
					err_count++;
				end
			end
		end
	end

	// watchdog: any accepted request or delivered result counts as progress
	always @(posedge clk) begin
		if ((start && !busy) || done)
			hang_cnt <= 0;
		else
			hang_cnt <= hang_cnt + 1;
		if (hang_cnt >= HANG_LIMIT) begin
			$display("%0t: no transaction for %0d cycles", $time, HANG_LIMIT);
			$display("Mismatches found");
			$finish;
		end
	end

	initial begin
		// shadow store after reset: free list 0 -> 1 -> ... -> last, stacks empty
		for (int i = 0; i < CAP; i++) begin
			slot_val[i]  = '0;
			slot_next[i] = (i + 1 < CAP) ? i + 1 : NIL;
		end
		for (int i = 0; i < NSTK; i++)
			top_slot[i] = NIL;
		free_slot = 0;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		test_empty_pops();
		test_fill_to_overflow();
		test_lifo_extremes();
		test_random_traffic(1250);

		start <= 1'b0;
		// drain, then keep watching to catch stray strobes
		while (pending_rsp.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);

		if (err_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
